@@ rtl/sarg_pkg.sv @@
package sarg_pkg;

  localparam int unsigned TotalW = 31;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  // Verdict codes
  localparam logic [1:0] VerdictSend = 2'd0;
  localparam logic [1:0] VerdictHold = 2'd1;
  localparam logic [1:0] VerdictDrop = 2'd2;

  // Reason codes
  localparam logic [3:0] ReasonNone        = 4'd0;
  localparam logic [3:0] ReasonNoRecipient = 4'd1;
  localparam logic [3:0] ReasonExpired     = 4'd2;
  localparam logic [3:0] ReasonNoLink      = 4'd3;
  localparam logic [3:0] ReasonPeerChanged = 4'd4;
  localparam logic [3:0] ReasonUnverified  = 4'd5;
  localparam logic [3:0] ReasonStarting    = 4'd6;
  localparam logic [3:0] ReasonBusy        = 4'd7;
  localparam logic [3:0] ReasonBudget      = 4'd8;
  localparam logic [3:0] ReasonSpacing     = 4'd9;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegBusyPendingLimit = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPeerBudgetBytes  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPeerSpacingMs    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDirectWindowBytes = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDirectSpacingMs  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegWindowLengthMs   = 3'd5;

  typedef struct packed {
    logic        kind;
    logic [31:0] now_ms;
    logic [63:0] dest_id;
    logic [31:0] queued_at_ms;
    logic [31:0] lifetime_ms;
    logic [15:0] msg_bytes;
    logic        for_peer;
    logic        link_has_peer;
    logic [63:0] link_peer_id;
    logic        peer_verified;
    logic        link_running;
    logic [7:0]  pending_frames;
  } sarg_in_t;

  typedef struct packed {
    logic [1:0]        verdict;
    logic [3:0]        reason_code;
    logic [TotalW-1:0] peer_bytes_used;
  } sarg_out_t;

  typedef struct packed {
    logic [7:0]        busy_pending_limit;
    logic [TotalW-1:0] peer_budget_bytes;
    logic [15:0]       peer_spacing_ms;
    logic [TotalW-1:0] direct_window_bytes;
    logic [15:0]       direct_spacing_ms;
    logic [15:0]       window_length_ms;
  } sarg_cfg_t;

  typedef struct packed {
    logic [63:0]       budget_peer_id;
    logic [TotalW-1:0] peer_byte_total;
    logic [31:0]       last_peer_send_ms;
    logic [31:0]       last_direct_send_ms;
    logic [31:0]       window_start_ms;
    logic [TotalW-1:0] window_byte_total;
  } sarg_state_t;

endpackage

@@ rtl/sarg_judge.sv @@
module sarg_judge import sarg_pkg::*; (
  input  sarg_in_t    item_i,
  input  sarg_cfg_t   cfg_i,
  input  sarg_state_t state_i,
  output sarg_state_t state_o,
  output sarg_out_t   result_o
);

  logic [TotalW:0]   size_ext;
  logic [TotalW:0]   peer_sum;
  logic [TotalW:0]   win_sum;
  logic [TotalW-1:0] peer_sat;
  logic [TotalW-1:0] win_sat;
  logic              rebudget;
  logic [TotalW-1:0] peer_total_eff;
  logic [31:0]       peer_last_eff;
  logic              roll;
  logic [TotalW-1:0] win_total_eff;
  logic              busy;
  logic              expired;
  logic              peer_path;
  logic              note_peer;
  logic [31:0]       age;
  logic [31:0]       peer_gap;
  logic [31:0]       direct_gap;
  logic [31:0]       win_age;
  logic [TotalW:0]   peer_need;
  logic [TotalW:0]   win_need;
  logic [1:0]        verdict;
  logic [3:0]        reason;

  assign size_ext = {{(TotalW+1-16){1'b0}}, item_i.msg_bytes};

  // Saturating adds used by a note-sent transaction.
  assign peer_sum = {1'b0, state_i.peer_byte_total} + size_ext;
  assign win_sum  = {1'b0, state_i.window_byte_total} + size_ext;
  assign peer_sat = peer_sum[TotalW] ? TotalMax : peer_sum[TotalW-1:0];
  assign win_sat  = win_sum[TotalW] ? TotalMax : win_sum[TotalW-1:0];

  assign age     = item_i.now_ms - item_i.queued_at_ms;
  assign expired = age > item_i.lifetime_ms;

  assign peer_path = item_i.for_peer ||
                     (item_i.link_has_peer && (item_i.dest_id == item_i.link_peer_id));
  assign note_peer = item_i.for_peer || (item_i.dest_id == state_i.budget_peer_id);

  assign busy = item_i.link_has_peer && (item_i.pending_frames > cfg_i.busy_pending_limit);

  // A new peer restarts the session budget before the remaining checks see it.
  assign rebudget       = item_i.link_peer_id != state_i.budget_peer_id;
  assign peer_total_eff = rebudget ? '0 : state_i.peer_byte_total;
  assign peer_last_eff  = rebudget ? '0 : state_i.last_peer_send_ms;
  assign peer_need      = {1'b0, peer_total_eff} + size_ext;
  assign peer_gap       = item_i.now_ms - peer_last_eff;

  assign win_age       = item_i.now_ms - state_i.window_start_ms;
  assign roll          = win_age >= {16'd0, cfg_i.window_length_ms};
  assign win_total_eff = roll ? '0 : state_i.window_byte_total;
  assign win_need      = {1'b0, win_total_eff} + size_ext;
  assign direct_gap    = item_i.now_ms - state_i.last_direct_send_ms;

  always_comb begin
    state_o = state_i;
    verdict = VerdictSend;
    reason  = ReasonNone;
    if (item_i.kind) begin
      if (note_peer) begin
        state_o.last_peer_send_ms = item_i.now_ms;
        state_o.peer_byte_total   = peer_sat;
      end else begin
        state_o.last_direct_send_ms = item_i.now_ms;
        state_o.window_byte_total   = win_sat;
      end
    end else if (item_i.dest_id == 64'd0) begin
      verdict = VerdictDrop;
      reason  = ReasonNoRecipient;
    end else if (expired) begin
      verdict = VerdictDrop;
      reason  = ReasonExpired;
    end else if (peer_path) begin
      if (!item_i.link_has_peer) begin
        verdict = VerdictHold;
        reason  = ReasonNoLink;
      end else if (item_i.link_peer_id != item_i.dest_id) begin
        verdict = VerdictDrop;
        reason  = ReasonPeerChanged;
      end else begin
        if (rebudget) begin
          state_o.budget_peer_id    = item_i.link_peer_id;
          state_o.peer_byte_total   = '0;
          state_o.last_peer_send_ms = '0;
        end
        if (!item_i.peer_verified) begin
          verdict = VerdictDrop;
          reason  = ReasonUnverified;
        end else if (!item_i.link_running) begin
          verdict = VerdictHold;
          reason  = ReasonStarting;
        end else if (busy) begin
          verdict = VerdictHold;
          reason  = ReasonBusy;
        end else if (peer_need > {1'b0, cfg_i.peer_budget_bytes}) begin
          verdict = VerdictDrop;
          reason  = ReasonBudget;
        end else if ((peer_last_eff != 32'd0) &&
                     (peer_gap < {16'd0, cfg_i.peer_spacing_ms})) begin
          verdict = VerdictHold;
          reason  = ReasonSpacing;
        end
      end
    end else begin
      if (busy) begin
        verdict = VerdictHold;
        reason  = ReasonBusy;
      end else begin
        if (roll) begin
          state_o.window_start_ms   = item_i.now_ms;
          state_o.window_byte_total = '0;
        end
        // A full window is reported as a spacing hold.
        if (win_need > {1'b0, cfg_i.direct_window_bytes}) begin
          verdict = VerdictHold;
          reason  = ReasonSpacing;
        end else if ((state_i.last_direct_send_ms != 32'd0) &&
                     (direct_gap < {16'd0, cfg_i.direct_spacing_ms})) begin
          verdict = VerdictHold;
          reason  = ReasonSpacing;
        end
      end
    end
  end

  assign result_o.verdict         = verdict;
  assign result_o.reason_code     = reason;
  assign result_o.peer_bytes_used = state_o.peer_byte_total;

endmodule

@@ rtl/send_admission_rate_gate_core.sv @@
// A transaction accepted into the input register is judged combinationally, and its
// result enters the output register when that register is free or draining.
// Throughput: one transaction per cycle while the output drains; the state update
// and verdict are one combinational pass, so items follow back to back.
// Reset (rst_ni low, asynchronous): configuration returns to its defaults,
// all counters, times and the budget peer id clear, and both stages empty.
module send_admission_rate_gate_core import sarg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TotalW-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sarg_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sarg_out_t          out_data_o
);

  sarg_cfg_t   cfg_q;
  sarg_state_t state_q;
  sarg_state_t state_d;
  sarg_in_t    item_q;
  logic        item_valid_q;
  sarg_out_t   result_d;
  sarg_out_t   result_q;
  logic        result_valid_q;
  logic        advance;

  // The staged item moves on whenever the result register is free or draining.
  assign advance    = item_valid_q && (!result_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  sarg_judge u_judge (
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.busy_pending_limit  <= 8'd8;
      cfg_q.peer_budget_bytes   <= 31'd65536;
      cfg_q.peer_spacing_ms     <= 16'd100;
      cfg_q.direct_window_bytes <= 31'd4096;
      cfg_q.direct_spacing_ms   <= 16'd50;
      cfg_q.window_length_ms    <= 16'd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBusyPendingLimit:  cfg_q.busy_pending_limit  <= cfg_wdata_i[7:0];
        RegPeerBudgetBytes:   cfg_q.peer_budget_bytes   <= cfg_wdata_i;
        RegPeerSpacingMs:     cfg_q.peer_spacing_ms     <= cfg_wdata_i[15:0];
        RegDirectWindowBytes: cfg_q.direct_window_bytes <= cfg_wdata_i;
        RegDirectSpacingMs:   cfg_q.direct_spacing_ms   <= cfg_wdata_i[15:0];
        RegWindowLengthMs:    cfg_q.window_length_ms    <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q   <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (advance) begin
        result_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        result_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = result_valid_q;
  assign out_data_o  = result_q;

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  import sarg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;

  localparam logic [63:0] PeerA = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PeerB = 64'h0000_0000_0000_0001;
  localparam logic [63:0] PeerC = 64'h5A5A_C3C3_0F0F_9696;
  localparam logic [63:0] DirectDest = 64'h8000_0000_0000_0001;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [TotalW-1:0]  cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  sarg_in_t           in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  sarg_out_t          out_data_o;

  // Shadow of the gate's registers and counters.
  sarg_cfg_t   gate_cfg;
  sarg_state_t gate_st;

  sarg_out_t   expected_verdicts[$];

  int          tx_idle_pct;
  int          rx_idle_pct;
  int          rx_hold_len;
  int          n_mismatch;
  int          n_sent;
  int          n_checked;
  int          n_settings;
  logic [15:0] reasons_seen;

  logic [31:0] traffic_ms;
  logic [63:0] peer_pool [0:2];
  int          link_sel;

  send_admission_rate_gate_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [TotalW-1:0] add_capped(input logic [TotalW-1:0] total,
                                                   input logic [15:0] n);
    logic [TotalW:0] sum;
    sum = {1'b0, total} + {16'd0, n};
    if (sum > {1'b0, TotalMax}) return TotalMax;
    return sum[TotalW-1:0];
  endfunction

  function automatic sarg_out_t judge_request(input sarg_in_t it);
    sarg_out_t   res;
    logic [31:0] age;
    logic [31:0] need;
    logic        busy;
    res.verdict     = VerdictSend;
    res.reason_code = ReasonNone;
    age  = it.now_ms - it.queued_at_ms;
    busy = it.link_has_peer && (it.pending_frames > gate_cfg.busy_pending_limit);
    if (it.kind) begin
      if (it.for_peer || it.dest_id == gate_st.budget_peer_id) begin
        gate_st.last_peer_send_ms = it.now_ms;
        gate_st.peer_byte_total   = add_capped(gate_st.peer_byte_total, it.msg_bytes);
      end else begin
        gate_st.last_direct_send_ms = it.now_ms;
        gate_st.window_byte_total   = add_capped(gate_st.window_byte_total, it.msg_bytes);
      end
    end else if (it.dest_id == '0) begin
      res.verdict     = VerdictDrop;
      res.reason_code = ReasonNoRecipient;
    end else if (age > it.lifetime_ms) begin
      res.verdict     = VerdictDrop;
      res.reason_code = ReasonExpired;
    end else if (it.for_peer || (it.link_has_peer && it.dest_id == it.link_peer_id)) begin
      if (!it.link_has_peer) begin
        res.verdict     = VerdictHold;
        res.reason_code = ReasonNoLink;
      end else if (it.link_peer_id != it.dest_id) begin
        res.verdict     = VerdictDrop;
        res.reason_code = ReasonPeerChanged;
      end else begin
        // A new peer starts a fresh session budget.
        if (it.link_peer_id != gate_st.budget_peer_id) begin
          gate_st.budget_peer_id    = it.link_peer_id;
          gate_st.peer_byte_total   = '0;
          gate_st.last_peer_send_ms = '0;
        end
        need = {1'b0, gate_st.peer_byte_total} + {16'd0, it.msg_bytes};
        if (!it.peer_verified) begin
          res.verdict     = VerdictDrop;
          res.reason_code = ReasonUnverified;
        end else if (!it.link_running) begin
          res.verdict     = VerdictHold;
          res.reason_code = ReasonStarting;
        end else if (busy) begin
          res.verdict     = VerdictHold;
          res.reason_code = ReasonBusy;
        end else if (need > {1'b0, gate_cfg.peer_budget_bytes}) begin
          res.verdict     = VerdictDrop;
          res.reason_code = ReasonBudget;
        end else if (gate_st.last_peer_send_ms != '0 &&
                     it.now_ms - gate_st.last_peer_send_ms <
                     {16'd0, gate_cfg.peer_spacing_ms}) begin
          res.verdict     = VerdictHold;
          res.reason_code = ReasonSpacing;
        end
      end
    end else if (busy) begin
      res.verdict     = VerdictHold;
      res.reason_code = ReasonBusy;
    end else begin
      if (it.now_ms - gate_st.window_start_ms >= {16'd0, gate_cfg.window_length_ms}) begin
        gate_st.window_start_ms   = it.now_ms;
        gate_st.window_byte_total = '0;
      end
      need = {1'b0, gate_st.window_byte_total} + {16'd0, it.msg_bytes};
      // A full window is reported as a spacing hold.
      if (need > {1'b0, gate_cfg.direct_window_bytes}) begin
        res.verdict     = VerdictHold;
        res.reason_code = ReasonSpacing;
      end else if (gate_st.last_direct_send_ms != '0 &&
                   it.now_ms - gate_st.last_direct_send_ms <
                   {16'd0, gate_cfg.direct_spacing_ms}) begin
        res.verdict     = VerdictHold;
        res.reason_code = ReasonSpacing;
      end
    end
    res.peer_bytes_used = gate_st.peer_byte_total;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  task automatic send_item(input sarg_in_t it);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do begin
        @(posedge clk_i);
      end while ($urandom_range(99) < tx_idle_pct);
    end
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    expected_verdicts.push_back(judge_request(it));
    n_sent++;
  endtask

  task automatic finish_phase();
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TotalW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      RegBusyPendingLimit:  gate_cfg.busy_pending_limit  = val[7:0];
      RegPeerBudgetBytes:   gate_cfg.peer_budget_bytes   = val;
      RegPeerSpacingMs:     gate_cfg.peer_spacing_ms     = val[15:0];
      RegDirectWindowBytes: gate_cfg.direct_window_bytes = val;
      RegDirectSpacingMs:   gate_cfg.direct_spacing_ms   = val[15:0];
      RegWindowLengthMs:    gate_cfg.window_length_ms    = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [TotalW-1:0] busy_limit,
                            input logic [TotalW-1:0] peer_budget,
                            input logic [TotalW-1:0] peer_gap,
                            input logic [TotalW-1:0] window_bytes,
                            input logic [TotalW-1:0] direct_gap,
                            input logic [TotalW-1:0] window_len);
    write_reg(RegBusyPendingLimit, busy_limit);
    write_reg(RegPeerBudgetBytes, peer_budget);
    write_reg(RegPeerSpacingMs, peer_gap);
    write_reg(RegDirectWindowBytes, window_bytes);
    write_reg(RegDirectSpacingMs, direct_gap);
    write_reg(RegWindowLengthMs, window_len);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Mostly plausible traffic on a slowly advancing clock with a sticky link
  // peer; about one transaction in eight is fully random.
  function automatic sarg_in_t make_traffic_item();
    sarg_in_t     it;
    logic [255:0] raw;
    logic [63:0]  peer;
    raw = {$urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
    it  = raw[$bits(sarg_in_t)-1:0];
    if ($urandom_range(99) < 12) return it;
    traffic_ms += $urandom_range(0, 140);
    if ($urandom_range(19) == 0) link_sel = $urandom_range(0, 2);
    peer             = peer_pool[link_sel];
    it.kind          = ($urandom_range(99) < 35);
    it.now_ms        = traffic_ms;
    it.link_has_peer = ($urandom_range(9) != 0);
    it.link_peer_id  = peer;
    if ($urandom_range(1) != 0) begin
      it.dest_id  = ($urandom_range(19) == 0) ? peer_pool[$urandom_range(0, 2)] : peer;
      it.for_peer = ($urandom_range(3) != 0);
    end else begin
      it.dest_id  = {$urandom, $urandom};
      it.for_peer = 1'b0;
    end
    if ($urandom_range(49) == 0) it.dest_id = '0;
    it.queued_at_ms   = traffic_ms - $urandom_range(0, 300);
    it.lifetime_ms    = ($urandom_range(4) == 0) ? $urandom_range(0, 300)
                                                 : $urandom_range(250, 5000);
    it.msg_bytes      = ($urandom_range(99) < 85) ? 16'($urandom_range(1, 2500))
                                                  : 16'($urandom_range(0, 65535));
    it.peer_verified  = ($urandom_range(24) != 0);
    it.link_running   = ($urandom_range(19) != 0);
    it.pending_frames = ($urandom_range(9) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 10));
    return it;
  endfunction

  task automatic drive_traffic(input int count);
    for (int i = 0; i < count; i++) send_item(make_traffic_item());
  endtask

  function automatic sarg_in_t at_time(input sarg_in_t it, input logic [31:0] t);
    sarg_in_t r;
    r              = it;
    r.now_ms       = t;
    r.queued_at_ms = t;
    return r;
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int n;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_len > 0) begin
        n           = rx_hold_len;
        rx_hold_len = 0;
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    sarg_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_verdicts.size() == 0) begin
        n_mismatch++;
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
      end else begin
        want = expected_verdicts.pop_front();
        n_checked++;
        reasons_seen[out_data_o.reason_code] = 1'b1;
        if (out_data_o.verdict !== want.verdict) begin
          n_mismatch++;
          $display("%0t: verdict expected %0d actual %0d",
                   $time, want.verdict, out_data_o.verdict);
        end
        if (out_data_o.reason_code !== want.reason_code) begin
          n_mismatch++;
          $display("%0t: reason_code expected %0d actual %0d",
                   $time, want.reason_code, out_data_o.reason_code);
        end
        if (out_data_o.peer_bytes_used !== want.peer_bytes_used) begin
          n_mismatch++;
          $display("%0t: peer_bytes_used expected %0d actual %0d",
                   $time, want.peer_bytes_used, out_data_o.peer_bytes_used);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walks every verdict path under the reset register values.
  task automatic test_reset_defaults();
    sarg_in_t base;
    sarg_in_t it;
    base                = '0;
    base.lifetime_ms    = 32'd100;
    base.msg_bytes      = 16'd100;
    base.for_peer       = 1'b1;
    base.dest_id        = PeerA;
    base.link_has_peer  = 1'b1;
    base.link_peer_id   = PeerA;
    base.peer_verified  = 1'b1;
    base.link_running   = 1'b1;
    base                = at_time(base, 32'd1000);

    it = base; it.dest_id = '0; send_item(it);
    // Queued one ms in the future: the age wraps and the request is expired,
    // unless the lifetime is the largest value.
    it = base; it.queued_at_ms = 32'd1001; send_item(it);
    it = base; it.queued_at_ms = 32'd1001; it.lifetime_ms = '1;
    it.link_has_peer = 1'b0; send_item(it);
    it = base; it.link_peer_id = PeerB; send_item(it);
    it = base; it.peer_verified = 1'b0; send_item(it);
    it = base; it.link_running = 1'b0; send_item(it);
    it = base; it.pending_frames = 8'd9; send_item(it);
    it = base; it.pending_frames = 8'd8; it.for_peer = 1'b0; send_item(it);
    it = base; it.kind = 1'b1; it.for_peer = 1'b0; send_item(it);
    it = at_time(base, 32'd1050); send_item(it);
    it = at_time(base, 32'd1100); send_item(it);
    it = at_time(base, 32'd1100); it.msg_bytes = 16'hFFFF; send_item(it);
    it = at_time(base, 32'd5); it.dest_id = PeerB; it.link_peer_id = PeerB;
    it.msg_bytes = 16'd1; send_item(it);
    // A send noted at time zero still reads as never sent.
    it = at_time(base, 32'd0); it.kind = 1'b1; it.dest_id = PeerB;
    it.link_peer_id = PeerB; send_item(it);
    it = at_time(base, 32'd10); it.dest_id = PeerB; it.link_peer_id = PeerB; send_item(it);

    base.dest_id      = DirectDest;
    base.for_peer     = 1'b0;
    base.link_peer_id = PeerB;
    it = at_time(base, 32'd2000); it.pending_frames = 8'hFF; send_item(it);
    it = at_time(base, 32'd2000); it.pending_frames = 8'hFF; it.link_has_peer = 1'b0;
    send_item(it);
    it = at_time(base, 32'd2000); it.kind = 1'b1; it.msg_bytes = 16'd4000; send_item(it);
    it = at_time(base, 32'd2100); send_item(it);
    it = at_time(base, 32'd3000); it.msg_bytes = 16'd10; send_item(it);
    it = at_time(base, 32'd3010); it.kind = 1'b1; it.msg_bytes = 16'd10; send_item(it);
    it = at_time(base, 32'd3020); it.msg_bytes = 16'd10; send_item(it);
    it = at_time(base, 32'd3030); it.kind = 1'b1; it.dest_id = '0; send_item(it);
    // The link peer as recipient takes the peer path only while linked.
    it = at_time(base, 32'd3200); it.dest_id = PeerB; it.link_has_peer = 1'b0;
    send_item(it);
    finish_phase();
  endtask

  task automatic test_traffic_mid();
    // Junk above bit 7 and bit 15 of the narrow registers must be dropped.
    set_config(31'h7FFF_FF06, 31'd12000, 31'h1234_0050, 31'd3000, 31'h5555_001E,
               31'h2AAA_0190);
    traffic_ms = 32'hFFFF_F000;
    drive_traffic(200);
    finish_phase();
  endtask

  task automatic test_traffic_max();
    set_config(31'd255, TotalMax, 31'd65535, TotalMax, 31'd65535, 31'd65535);
    traffic_ms = 32'd0;
    drive_traffic(150);
    finish_phase();
  endtask

  task automatic test_traffic_min();
    set_config(31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0);
    traffic_ms = 32'h8000_0000;
    drive_traffic(120);
    finish_phase();
  endtask

  task automatic test_traffic_tight();
    set_config(31'd3, 31'd30000, 31'd1, 31'd6000, 31'd200, 31'd1);
    traffic_ms = 32'h0001_0000;
    drive_traffic(200);
    finish_phase();
  endtask

  // The receiver holds off long enough for the gate to fill and stall its input.
  task automatic test_output_stall();
    rx_hold_len = 300;
    drive_traffic(12);
    finish_phase();
  endtask

  task automatic test_unused_register();
    write_reg(RegUnusedLo, 31'd0);
    write_reg(RegUnusedHi, TotalMax);
    cfg_we_i <= 1'b0;
    drive_traffic(10);
    finish_phase();
  endtask

  // Back-to-back full-size notes build up both byte totals far past the defaults.
  task automatic test_full_size_notes();
    sarg_in_t base;
    sarg_in_t it;
    set_config(31'd8, TotalMax, 31'd0, TotalMax, 31'd0, 31'd65535);
    base               = '0;
    base.dest_id       = PeerC;
    base.lifetime_ms   = '1;
    base.msg_bytes     = 16'hFFFF;
    base.for_peer      = 1'b1;
    base.link_has_peer = 1'b1;
    base.link_peer_id  = PeerC;
    base.peer_verified = 1'b1;
    base.link_running  = 1'b1;
    base               = at_time(base, 32'd7);
    send_item(base);
    for (int i = 0; i < 16; i++) begin
      it = base; it.kind = 1'b1; send_item(it);
      it = base; it.kind = 1'b1; it.for_peer = 1'b0; it.dest_id = DirectDest;
      send_item(it);
    end
    it = base; it.msg_bytes = 16'd1; send_item(it);
    it = at_time(base, gate_st.window_start_ms); it.msg_bytes = 16'd1;
    it.for_peer = 1'b0; it.dest_id = DirectDest; it.link_has_peer = 1'b0;
    send_item(it);
    finish_phase();
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= '0;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    in_data_i    <= '0;
    rx_hold_len  = 0;
    n_mismatch   = 0;
    n_sent       = 0;
    n_checked    = 0;
    n_settings   = 1;
    reasons_seen = '0;
    link_sel     = 0;
    traffic_ms   = '0;
    peer_pool[0] = PeerA;
    peer_pool[1] = PeerB;
    peer_pool[2] = PeerC;

    gate_cfg.busy_pending_limit  = 8'd8;
    gate_cfg.peer_budget_bytes   = 31'd65536;
    gate_cfg.peer_spacing_ms     = 16'd100;
    gate_cfg.direct_window_bytes = 31'd4096;
    gate_cfg.direct_spacing_ms   = 16'd50;
    gate_cfg.window_length_ms    = 16'd1000;
    gate_st                      = '0;

    tx_idle_pct = 19;
    rx_idle_pct = 68;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_traffic_mid();

    tx_idle_pct = 68;
    rx_idle_pct = 19;
    test_traffic_max();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_traffic_min();
    test_traffic_tight();
    test_output_stall();
    test_unused_register();
    test_full_size_notes();

    $display("Covered %0d transactions with %0d results checked under %0d register settings.",
             n_sent, n_checked, n_settings);
    $display("Reason codes observed, one bit per code: %b", reasons_seen);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
